[sv/block_cache_directory_lru_core_assert.svh]
// Assertion macros shared by the buffer cache directory modules.
`ifndef BLOCK_CACHE_DIRECTORY_LRU_CORE_ASSERT_SVH
`define BLOCK_CACHE_DIRECTORY_LRU_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define BCD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define BCD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/bcd_pkg.sv]
// Types and constants of the buffer cache directory.
package bcd_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = 4;
	localparam int BLOCK_W  = 40;
	localparam int PIN_W    = 8;
	localparam int RANK_W   = 4;
	localparam int CNT_W    = 5;
	localparam int ACT_W    = 3;
	localparam int STS_W    = 3;
	localparam int APB_DW   = 32;
	localparam int APB_AW   = 2;

	localparam logic [CNT_W-1:0]  MAX_ENTRIES_RESET = 5'd16;
	localparam logic [APB_AW-1:0] REG_MAX_ENTRIES   = 2'd0;

	typedef enum logic [ACT_W-1:0] {
		ACT_ACQUIRE    = 3'd0,
		ACT_RELEASE    = 3'd1,
		ACT_MARK_DIRTY = 3'd2,
		ACT_DELAYED    = 3'd3,
		ACT_WRITE_DONE = 3'd4,
		ACT_SYNC       = 3'd5,
		ACT_INVALIDATE = 3'd6,
		ACT_NOP        = 3'd7
	} action_t;

	typedef enum logic [STS_W-1:0] {
		ST_HIT         = 3'd0,
		ST_MISS_FREE   = 3'd1,
		ST_EVICT_CLEAN = 3'd2,
		ST_EVICT_DIRTY = 3'd3,
		ST_NO_ROOM     = 3'd4,
		ST_DONE        = 3'd5,
		ST_BAD_SLOT    = 3'd6,
		ST_SYNC_WB     = 3'd7
	} status_t;

	typedef struct packed {
		logic load;
		logic eval;
		logic apply;
		logic sync_emit;
		logic sync_skip;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic sync_go;
		logic sync_found;
		logic sync_end;
	} stat_t;

endpackage

[sv/bcd_if.sv]
// Request and response channel interfaces of the buffer cache directory.
interface bcd_in_if;
	import bcd_pkg::*;
	logic               valid;
	logic               ready;
	logic [ACT_W-1:0]   action;
	logic [BLOCK_W-1:0] block_number;
	logic [IDX_W-1:0]   slot;
	modport source (output valid, action, block_number, slot, input ready);
	modport sink (input valid, action, block_number, slot, output ready);
endinterface

interface bcd_out_if;
	import bcd_pkg::*;
	logic               valid;
	logic               ready;
	logic [STS_W-1:0]   status;
	logic [IDX_W-1:0]   slot_out;
	logic [BLOCK_W-1:0] victim_block;
	logic               writeback;
	logic               last;
	modport source (output valid, status, slot_out, victim_block, writeback, last, input ready);
	modport sink (input valid, status, slot_out, victim_block, writeback, last, output ready);
endinterface

[sv/bcd_dpath.sv]
// Directory datapath: entry state, lookup and victim selection, sync walk, response register.
`include "block_cache_directory_lru_core_assert.svh"

module bcd_dpath (
	input  logic                    clk,
	input  logic                    arst_n,
	input  bcd_pkg::cmd_t           cmd,
	output bcd_pkg::stat_t          stat,
	input  logic [2:0]              in_action,
	input  logic [39:0]             in_block,
	input  logic [3:0]              in_slot,
	input  logic                    cfg_we,
	input  logic [4:0]              cfg_data,
	output logic [4:0]              max_entries,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [2:0]              out_status,
	output logic [3:0]              out_slot,
	output logic [39:0]             out_victim,
	output logic                    out_writeback,
	output logic                    out_last
);
	import bcd_pkg::*;

	logic [ACT_W-1:0]    op_q;
	logic [BLOCK_W-1:0]  blk_q;
	logic [IDX_W-1:0]    slot_q;

	logic [CAPACITY-1:0] valid_q, dirty_q, delayed_q;
	logic [PIN_W-1:0]    pin_q [CAPACITY];
	logic [RANK_W-1:0]   rank_q [CAPACITY];
	logic [BLOCK_W-1:0]  blk_mem_q [CAPACITY];
	logic [CNT_W-1:0]    used_q, max_q, sync_r_q;

	status_t             dec_q;
	logic [IDX_W-1:0]    tgt_q;
	logic [BLOCK_W-1:0]  victim_q;

	logic                out_valid_q;
	status_t             out_status_q;
	logic [IDX_W-1:0]    out_slot_q;
	logic [BLOCK_W-1:0]  out_victim_q;
	logic                out_wb_q, out_last_q;

	logic [CAPACITY-1:0] hit_v, free_v, clean_c, dirty_c, clean_w, dirty_w;
	logic [CAPACITY-1:0] sync_sel, dirty_gt, keep;
	logic [CAPACITY-1:0] lower [CAPACITY];
	logic [RANK_W-1:0]   new_rank [CAPACITY];
	logic [CNT_W-1:0]    kept_cnt;
	logic [IDX_W-1:0]    hit_idx, free_idx, clean_idx, dirty_idx, sync_idx, rd_idx;
	logic [BLOCK_W-1:0]  rd_blk;
	status_t             dec_d;
	logic [IDX_W-1:0]    tgt_d;

	function automatic logic [IDX_W-1:0] first_set(input logic [CAPACITY-1:0] v);
		logic [IDX_W-1:0] idx;
		idx = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (v[i]) idx = IDX_W'(i);
		end
		return idx;
	endfunction

	// Candidate vectors; a winner is a candidate that no other candidate outranks.
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			hit_v[i]   = valid_q[i] && (blk_mem_q[i] == blk_q);
			free_v[i]  = !valid_q[i];
			clean_c[i] = valid_q[i] && (pin_q[i] == '0) && !dirty_q[i];
			dirty_c[i] = valid_q[i] && (pin_q[i] == '0) && dirty_q[i];
			sync_sel[i] = valid_q[i] && dirty_q[i] && ({1'b0, rank_q[i]} == sync_r_q);
			dirty_gt[i] = valid_q[i] && dirty_q[i] && ({1'b0, rank_q[i]} > sync_r_q);
			keep[i]    = valid_q[i] && (pin_q[i] != '0);
		end
		for (int i = 0; i < CAPACITY; i++) begin
			clean_w[i] = clean_c[i];
			dirty_w[i] = dirty_c[i];
			for (int j = 0; j < CAPACITY; j++) begin
				if (clean_c[j] && (rank_q[j] > rank_q[i])) clean_w[i] = 1'b0;
				if (dirty_c[j] && (rank_q[j] > rank_q[i])) dirty_w[i] = 1'b0;
				lower[i][j] = keep[j] && (rank_q[j] < rank_q[i]);
			end
			new_rank[i] = RANK_W'($countones(lower[i]));
		end
		kept_cnt = CNT_W'($countones(keep));
	end

	assign hit_idx   = first_set(hit_v);
	assign free_idx  = first_set(free_v);
	assign clean_idx = first_set(clean_w);
	assign dirty_idx = first_set(dirty_w);
	assign sync_idx  = first_set(sync_sel);
	assign rd_idx    = cmd.eval ? dirty_idx : sync_idx;
	assign rd_blk    = blk_mem_q[rd_idx];

	always_comb begin
		dec_d = ST_DONE;
		tgt_d = '0;
		case (action_t'(op_q))
			ACT_ACQUIRE: begin
				if (|hit_v) begin
					dec_d = ST_HIT;
					tgt_d = hit_idx;
				end else if ((used_q < max_q) && (|free_v)) begin
					dec_d = ST_MISS_FREE;
					tgt_d = free_idx;
				end else if (|clean_w) begin
					dec_d = ST_EVICT_CLEAN;
					tgt_d = clean_idx;
				end else if (|dirty_w) begin
					dec_d = ST_EVICT_DIRTY;
					tgt_d = dirty_idx;
				end else begin
					dec_d = ST_NO_ROOM;
				end
			end
			ACT_RELEASE, ACT_MARK_DIRTY, ACT_DELAYED, ACT_WRITE_DONE: begin
				dec_d = valid_q[slot_q] ? ST_DONE : ST_BAD_SLOT;
				tgt_d = slot_q;
			end
			ACT_SYNC: begin
				dec_d = (|(valid_q & dirty_q)) ? ST_SYNC_WB : ST_DONE;
			end
			default: begin
				dec_d = ST_DONE;
			end
		endcase
	end

	assign stat.out_free   = !out_valid_q || out_ready;
	assign stat.sync_go    = (dec_q == ST_SYNC_WB);
	assign stat.sync_found = |sync_sel;
	assign stat.sync_end   = !(|(sync_sel | dirty_gt));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			dirty_q     <= '0;
			delayed_q   <= '0;
			for (int i = 0; i < CAPACITY; i++) begin
				pin_q[i]  <= '0;
				rank_q[i] <= '0;
			end
			used_q      <= '0;
			max_q       <= MAX_ENTRIES_RESET;
			sync_r_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) max_q <= cfg_data;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (cmd.load) sync_r_q <= '0;
			if (cmd.apply) begin
				out_valid_q <= 1'b1;
				case (action_t'(op_q))
					ACT_ACQUIRE: begin
						if (dec_q != ST_NO_ROOM) begin
							// age every entry younger than the target; all of them on a fresh insert
							for (int i = 0; i < CAPACITY; i++) begin
								if (valid_q[i] && (i != int'(tgt_q)) &&
								    (!valid_q[tgt_q] || (rank_q[i] < rank_q[tgt_q])))
									rank_q[i] <= rank_q[i] + RANK_W'(1);
							end
							rank_q[tgt_q]  <= '0;
							valid_q[tgt_q] <= 1'b1;
							if (dec_q == ST_HIT) begin
								if (pin_q[tgt_q] != '1) pin_q[tgt_q] <= pin_q[tgt_q] + PIN_W'(1);
							end else begin
								pin_q[tgt_q]     <= PIN_W'(1);
								dirty_q[tgt_q]   <= 1'b0;
								delayed_q[tgt_q] <= 1'b0;
							end
							if (dec_q == ST_MISS_FREE) used_q <= used_q + CNT_W'(1);
						end
					end
					ACT_RELEASE: begin
						if ((dec_q == ST_DONE) && (pin_q[tgt_q] != '0))
							pin_q[tgt_q] <= pin_q[tgt_q] - PIN_W'(1);
					end
					ACT_MARK_DIRTY: begin
						if (dec_q == ST_DONE) dirty_q[tgt_q] <= 1'b1;
					end
					ACT_DELAYED: begin
						if (dec_q == ST_DONE) begin
							dirty_q[tgt_q]   <= 1'b1;
							delayed_q[tgt_q] <= 1'b1;
						end
					end
					ACT_WRITE_DONE: begin
						if (dec_q == ST_DONE) begin
							dirty_q[tgt_q]   <= 1'b0;
							delayed_q[tgt_q] <= 1'b0;
						end
					end
					ACT_INVALIDATE: begin
						// drop unpinned entries and close up the ranks of the survivors
						for (int i = 0; i < CAPACITY; i++) begin
							if (keep[i]) begin
								rank_q[i] <= new_rank[i];
							end else if (valid_q[i]) begin
								valid_q[i]   <= 1'b0;
								pin_q[i]     <= '0;
								dirty_q[i]   <= 1'b0;
								delayed_q[i] <= 1'b0;
								rank_q[i]    <= '0;
							end
						end
						used_q <= kept_cnt;
					end
					default: begin
					end
				endcase
			end
			if (cmd.sync_emit) begin
				out_valid_q         <= 1'b1;
				dirty_q[sync_idx]   <= 1'b0;
				delayed_q[sync_idx] <= 1'b0;
				sync_r_q            <= sync_r_q + CNT_W'(1);
			end
			if (cmd.sync_skip) sync_r_q <= sync_r_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= in_action;
			blk_q  <= in_block;
			slot_q <= in_slot;
		end
		if (cmd.eval) begin
			dec_q    <= dec_d;
			tgt_q    <= tgt_d;
			victim_q <= rd_blk;
		end
		if (cmd.apply) begin
			if ((action_t'(op_q) == ACT_ACQUIRE) && (dec_q != ST_HIT) && (dec_q != ST_NO_ROOM))
				blk_mem_q[tgt_q] <= blk_q;
			out_status_q <= dec_q;
			out_slot_q   <= tgt_q;
			out_victim_q <= (dec_q == ST_EVICT_DIRTY) ? victim_q : '0;
			out_wb_q     <= (dec_q == ST_EVICT_DIRTY);
			out_last_q   <= 1'b1;
		end
		if (cmd.sync_emit) begin
			out_status_q <= ST_SYNC_WB;
			out_slot_q   <= sync_idx;
			out_victim_q <= rd_blk;
			out_wb_q     <= 1'b1;
			out_last_q   <= !(|dirty_gt);
		end
	end

	assign max_entries   = max_q;
	assign out_valid     = out_valid_q;
	assign out_status    = out_status_q;
	assign out_slot      = out_slot_q;
	assign out_victim    = out_victim_q;
	assign out_writeback = out_wb_q;
	assign out_last      = out_last_q;

	`BCD_ASSERT_NOW(a_used_matches_valid, 1'b1, used_q == CNT_W'($countones(valid_q)), "entry count drifted from valid entries")
	`BCD_ASSERT_NOW(a_no_resp_overwrite, cmd.apply || cmd.sync_emit, !out_valid_q || out_ready, "response overwritten before transfer")
	`BCD_ASSERT_NEXT(a_grant_is_mru, cmd.apply && (op_q == ACT_ACQUIRE) && (dec_q != ST_NO_ROOM), valid_q[tgt_q] && (rank_q[tgt_q] == '0), "granted entry is not valid MRU")

endmodule

[sv/bcd_ctrl.sv]
// Directory controller: sequences accept, evaluate, apply and the sync walk.
`include "block_cache_directory_lru_core_assert.svh"

module bcd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  bcd_pkg::stat_t stat,
	output bcd_pkg::cmd_t  cmd
);
	import bcd_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_APPLY,
		S_SYNC
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == S_IDLE) && in_valid;
		cmd.eval      = (state_q == S_EVAL);
		cmd.apply     = (state_q == S_APPLY) && !stat.sync_go && stat.out_free;
		cmd.sync_emit = (state_q == S_SYNC) && !stat.sync_end && stat.sync_found && stat.out_free;
		cmd.sync_skip = (state_q == S_SYNC) && !stat.sync_end && !stat.sync_found;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_EVAL;
				end
				S_EVAL: begin
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					if (stat.sync_go) state_q <= S_SYNC;
					else if (stat.out_free) state_q <= S_IDLE;
				end
				S_SYNC: begin
					if (stat.sync_end) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`BCD_ASSERT_NOW(a_cmd_onehot0, 1'b1, $onehot0(cmd), "more than one datapath command")
	`BCD_ASSERT_NEXT(a_load_then_eval, cmd.load, state_q == S_EVAL, "accepted request not evaluated")
	`BCD_ASSERT_NOW(a_sync_walk_flag, state_q == S_SYNC, stat.sync_go, "sync walk without sync decision")

endmodule

[sv/block_cache_directory_lru_core.sv]
// Buffer cache directory for 16 entries with pin counts, dirty and delayed-write marks and
// LRU ranks. A request is transferred, then evaluated (associative lookup, free slot and
// LRU victim search over all entries in parallel), then applied: the directory is updated
// and the response register loaded, stalling while the last response waits. A new request
// is not accepted until the last one is done. Sync walks the recency ranks one per cycle
// from MRU, emitting one writeback per dirty entry, each writeback waiting for a free
// response register, and closes the walk after the last dirty one. A new request is
// accepted while the last response still waits.
// max_entries (address 0) may be written only between requests.
module block_cache_directory_lru_core (
	input  logic        clk,
	input  logic        arst_n,
	bcd_in_if.sink      req,
	bcd_out_if.source   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import bcd_pkg::*;

	cmd_t             cmd;
	stat_t            stat;
	logic             cfg_we;
	logic [CNT_W-1:0] max_entries;

	assign cfg_we = psel && penable && pwrite;
	assign pready = 1'b1;
	assign prdata = (paddr == REG_MAX_ENTRIES) ? {{(APB_DW-CNT_W){1'b0}}, max_entries} : '0;

	bcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bcd_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.in_action     (req.action),
		.in_block      (req.block_number),
		.in_slot       (req.slot),
		.cfg_we        (cfg_we),
		.cfg_data      (pwdata[CNT_W-1:0]),
		.max_entries   (max_entries),
		.out_valid     (rsp.valid),
		.out_ready     (rsp.ready),
		.out_status    (rsp.status),
		.out_slot      (rsp.slot_out),
		.out_victim    (rsp.victim_block),
		.out_writeback (rsp.writeback),
		.out_last      (rsp.last)
	);

endmodule
